// ===== design/ocp_pkg.sv =====
// ocp_pkg: shared types, constants and helper functions of the orbit camera
// depends on nothing; used by the controller, datapath and top level
package ocp_pkg;

	// fixed-point formats
	localparam int ANG_FRAC    = 12;
	localparam int CORDIC_ITER = 16;
	localparam int ITER_W      = $clog2(CORDIC_ITER);
	localparam int CW          = 34;   // cordic x, y and angle width (Q30)
	localparam int RW          = 37;   // angle reduction width (Q30)

	localparam longint TWO_PI_Q30_L = 64'sd6746518852;
	localparam logic signed [RW-1:0] TWO_PI_Q30  = RW'(64'sd6746518852);
	localparam logic signed [RW-1:0] PI_Q30      = RW'(64'sd3373259426);
	localparam logic signed [RW-1:0] HALF_PI_Q30 = RW'(64'sd1686629713);
	localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
	localparam logic [14:0] TWO_PI_ANG =
		15'((TWO_PI_Q30_L + (64'sd1 <<< (29 - ANG_FRAC))) >>> (30 - ANG_FRAC));

	// action codes
	localparam logic [2:0] ACT_ORBIT    = 3'd0;
	localparam logic [2:0] ACT_ZOOM_OUT = 3'd1;
	localparam logic [2:0] ACT_ZOOM_IN  = 3'd2;
	localparam logic [2:0] ACT_RETARGET = 3'd3;
	localparam logic [2:0] ACT_LOAD     = 3'd4;

	// register indexes
	localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
	localparam logic [2:0] REG_DEAD_ZONE  = 3'd1;
	localparam logic [2:0] REG_INIT_RAD   = 3'd2;
	localparam logic [2:0] REG_INIT_AZ    = 3'd3;
	localparam logic [2:0] REG_INIT_EL    = 3'd4;
	localparam logic [2:0] REG_BOTTOM     = 3'd5;
	localparam logic [2:0] REG_TOP        = 3'd6;

	// register reset values
	localparam logic [15:0] RST_MOVE_SPEED = 16'd4096;
	localparam logic [11:0] RST_DEAD_ZONE  = 12'd4;
	localparam logic [17:0] RST_INIT_RAD   = 18'd2560;
	localparam logic [15:0] RST_INIT_AZ    = 16'd0;
	localparam logic [14:0] RST_INIT_EL    = 15'd6434;
	localparam logic [14:0] RST_BOTTOM     = 15'd0;
	localparam logic [14:0] RST_TOP        = 15'd12868;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [23:0] target_x;
		logic signed [23:0] target_y;
		logic signed [23:0] target_z;
	} cmd_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic               up_flipped;
		logic               moved;
	} pos_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [17:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [15:0] move_speed;
		logic [11:0] dead_zone;
		logic [17:0] initial_radius;
		logic [15:0] initial_azimuth;
		logic [14:0] initial_elevation;
		logic [14:0] bottom_angle;
		logic [14:0] top_angle;
	} cfg_regs_t;

	// controller to datapath
	typedef struct packed {
		logic              ld_cmd;
		logic              amt;
		logic              apply;
		logic              setup;
		logic              reduce;
		logic              fold;
		logic              rot;
		logic              sign;
		logic              mul1;
		logic              mul2;
		logic              load_out;
		logic [ITER_W-1:0] iter;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic red_done;
	} dp_stat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] a;
	} cordic_t;

	// truncated Q30 arctangent of 2^-i
	function automatic logic signed [CW-1:0] atan_q30(logic [4:0] idx);
		logic signed [CW-1:0] v;
		unique case (idx)
			5'd0:  v = CW'(32'h3243F6A8);
			5'd1:  v = CW'(32'h1DAC6705);
			5'd2:  v = CW'(32'h0FADBAFC);
			5'd3:  v = CW'(32'h07F56EA6);
			5'd4:  v = CW'(32'h03FEAB76);
			5'd5:  v = CW'(32'h01FFD55B);
			5'd6:  v = CW'(32'h00FFFAAA);
			5'd7:  v = CW'(32'h007FFF55);
			5'd8:  v = CW'(32'h003FFFEA);
			5'd9:  v = CW'(32'h001FFFFD);
			5'd10: v = CW'(32'h000FFFFF);
			5'd11: v = CW'(32'h0007FFFF);
			5'd12: v = CW'(32'h0003FFFF);
			5'd13: v = CW'(32'h0001FFFF);
			5'd14: v = CW'(32'h0000FFFF);
			5'd15: v = CW'(32'h00007FFF);
			5'd16: v = CW'(32'h00003FFF);
			5'd17: v = CW'(32'h00001FFF);
			5'd18: v = CW'(32'h00000FFF);
			5'd19: v = CW'(32'h000007FF);
			5'd20: v = CW'(32'h000003FF);
			5'd21: v = CW'(32'h000001FF);
			5'd22: v = CW'(32'h000000FF);
			5'd23: v = CW'(32'h0000007F);
			default: v = '0;
		endcase
		return v;
	endfunction

	// one rotation-mode iteration, shifts floor toward minus infinity
	function automatic cordic_t cordic_step(cordic_t c, logic [ITER_W-1:0] i);
		cordic_t r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = c.x >>> i;
		ys = c.y >>> i;
		if (!c.a[CW-1]) begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.a = c.a - atan_q30(5'(i));
		end else begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.a = c.a + atan_q30(5'(i));
		end
		return r;
	endfunction

	// clamp to the 18 bit signed angle range
	function automatic logic signed [17:0] sat_ang(logic signed [22:0] v);
		logic signed [17:0] r;
		if (v > 23'sd131071)
			r = 18'sh1FFFF;
		else if (v < -23'sd131072)
			r = 18'sh20000;
		else
			r = v[17:0];
		return r;
	endfunction

	// clamp to the 24 bit signed coordinate range
	function automatic logic signed [23:0] sat_pos(logic signed [24:0] v);
		logic signed [23:0] r;
		if (v[24] != v[23])
			r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage

// ===== design/ocp_chan_if.sv =====
// ocp_chan_if: valid/ready channel carrying one payload of a given type
// payload types come from ocp_pkg at the place of instantiation
interface ocp_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/ocp_ctrl.sv =====
// ocp_ctrl: sequencing state machine of the orbit camera
// depends on ocp_pkg for the command and status structs
module ocp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ocp_pkg::ctl_cmd_t ctl,
	input  ocp_pkg::dp_stat_t stat
);
	import ocp_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_AMT    = 11'b000_0000_0010,
		ST_APPLY  = 11'b000_0000_0100,
		ST_SETUP  = 11'b000_0000_1000,
		ST_REDUCE = 11'b000_0001_0000,
		ST_FOLD   = 11'b000_0010_0000,
		ST_ROT    = 11'b000_0100_0000,
		ST_SIGN   = 11'b000_1000_0000,
		ST_MUL1   = 11'b001_0000_0000,
		ST_MUL2   = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              cmd_xfer;
	logic              out_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd_xfer) state_d = ST_AMT;
			ST_AMT:    state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_SETUP;
			ST_SETUP:  state_d = ST_REDUCE;
			ST_REDUCE: if (stat.red_done) state_d = ST_FOLD;
			ST_FOLD:   state_d = ST_ROT;
			ST_ROT:    if (iter_q == ITER_W'(CORDIC_ITER - 1)) state_d = ST_SIGN;
			ST_SIGN:   state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl          = '0;
		ctl.ld_cmd   = cmd_xfer;
		ctl.amt      = (state_q == ST_AMT);
		ctl.apply    = (state_q == ST_APPLY);
		ctl.setup    = (state_q == ST_SETUP);
		ctl.reduce   = (state_q == ST_REDUCE);
		ctl.fold     = (state_q == ST_FOLD);
		ctl.rot      = (state_q == ST_ROT);
		ctl.sign     = (state_q == ST_SIGN);
		ctl.mul1     = (state_q == ST_MUL1);
		ctl.mul2     = (state_q == ST_MUL2);
		ctl.load_out = (state_q == ST_FIN) && out_free;
		ctl.iter     = iter_q;
	end

	// state, iteration counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROT)
				iter_q <= iter_q + 1'b1;
			else
				iter_q <= '0;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/ocp_dp.sv =====
// ocp_dp: camera state, angle update, angle reduction, two cordic units and
// the position multipliers; depends on ocp_pkg
module ocp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ocp_pkg::ctl_cmd_t  ctl,
	output ocp_pkg::dp_stat_t  stat,
	input  ocp_pkg::cfg_regs_t cfg,
	input  ocp_pkg::cmd_t      cmd_data,
	output ocp_pkg::pos_t      out_data
);
	import ocp_pkg::*;

	cmd_t                 cmd_q;
	logic signed [20:0]   amt_az_s1;
	logic signed [20:0]   amt_el_s1;
	logic                 en_az_s1;
	logic                 en_el_s1;
	logic                 moved_q;

	logic signed [19:0]   radius_q;
	logic signed [17:0]   az_q;
	logic signed [17:0]   el_q;
	logic signed [23:0]   tx_q;
	logic signed [23:0]   ty_q;
	logic signed [23:0]   tz_q;
	logic                 flip_q;

	logic signed [RW-1:0] red_el_q;
	logic signed [RW-1:0] red_az_q;
	cordic_t              cor_el_q;
	cordic_t              cor_az_q;
	logic                 neg_el_q;
	logic                 neg_az_q;
	logic signed [CW-1:0] st_q;
	logic signed [CW-1:0] ct_q;
	logic signed [CW-1:0] sp_q;
	logic signed [CW-1:0] cp_q;
	logic signed [21:0]   rs_q;
	logic signed [21:0]   py_q;
	logic signed [21:0]   px_q;
	logic signed [21:0]   pz_q;
	pos_t                 out_q;

	// orbit amounts
	logic signed [32:0]   prod_x;
	logic signed [32:0]   prod_y;
	logic [16:0]          mag_dx;
	logic [16:0]          mag_dy;

	// angle update
	logic signed [21:0]   az_sum;
	logic [21:0]          az_mag;
	logic signed [22:0]   az_wrap;
	logic signed [21:0]   el_sum;
	logic signed [22:0]   el_wrap;
	logic signed [17:0]   el_new;
	logic signed [17:0]   el_lo;
	logic signed [17:0]   el_hi;
	logic signed [17:0]   bot_s;
	logic signed [17:0]   top_s;
	logic [21:0]          wrap_lim;
	logic signed [20:0]   rad_sum;
	logic signed [19:0]   rad_sat;
	logic signed [12:0]   zoom_step;

	// reduction and folding
	logic                 el_in_range;
	logic                 az_in_range;
	logic signed [RW-1:0] fold_el;
	logic signed [RW-1:0] fold_az;
	logic                 fneg_el;
	logic                 fneg_az;

	// multipliers
	logic signed [53:0]   prod_rs;
	logic signed [53:0]   prod_py;
	logic signed [55:0]   prod_px;
	logic signed [55:0]   prod_pz;

	// fold one reduced angle into [-pi/2, pi/2] with a sign flag
	function automatic logic signed [RW:0] fold_ang(logic signed [RW-1:0] a0);
		logic signed [RW-1:0] a1;
		logic signed [RW-1:0] a2;
		logic                 n;
		a1 = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
		n  = 1'b0;
		if (a1 > HALF_PI_Q30) begin
			a2 = a1 - PI_Q30;
			n  = 1'b1;
		end else if (a1 < -HALF_PI_Q30) begin
			a2 = a1 + PI_Q30;
			n  = 1'b1;
		end else begin
			a2 = a1;
		end
		return {n, a2};
	endfunction

	assign prod_x = cmd_q.dir_x * $signed({1'b0, cfg.move_speed});
	assign prod_y = cmd_q.dir_y * $signed({1'b0, cfg.move_speed});
	assign mag_dx = cmd_q.dir_x[15] ? 17'(-$signed({cmd_q.dir_x[15], cmd_q.dir_x}))
	                                : {1'b0, cmd_q.dir_x};
	assign mag_dy = cmd_q.dir_y[15] ? 17'(-$signed({cmd_q.dir_y[15], cmd_q.dir_y}))
	                                : {1'b0, cmd_q.dir_y};

	assign wrap_lim = 22'(TWO_PI_ANG) + 22'(cfg.dead_zone);

	// azimuth: add, wrap once toward zero, clamp
	always_comb begin
		az_sum = 22'(az_q) + 22'(amt_az_s1);
		az_mag = az_sum[21] ? 22'(-az_sum) : az_sum;
		if (az_mag > wrap_lim)
			az_wrap = az_sum[21] ? 23'(az_sum) + 23'(TWO_PI_ANG)
			                     : 23'(az_sum) - 23'(TWO_PI_ANG);
		else
			az_wrap = 23'(az_sum);
	end

	// elevation: add, wrap into one turn, clamp, detect crossings
	always_comb begin
		el_sum = 22'(el_q) + 22'(amt_el_s1);
		if (el_sum[21])
			el_wrap = 23'(el_sum) + 23'(TWO_PI_ANG);
		else if (el_sum > $signed(wrap_lim))
			el_wrap = 23'(el_sum) - 23'(TWO_PI_ANG);
		else
			el_wrap = 23'(el_sum);
		el_new = sat_ang(el_wrap);
		el_lo  = (el_q > el_new) ? el_new : el_q;
		el_hi  = (el_q > el_new) ? el_q : el_new;
		bot_s  = $signed({3'b000, cfg.bottom_angle});
		top_s  = $signed({3'b000, cfg.top_angle});
	end

	// radius zoom with clamp
	always_comb begin
		zoom_step = $signed({1'b0, cfg.move_speed[15:4]});
		if (cmd_q.action == ACT_ZOOM_OUT)
			rad_sum = 21'(radius_q) + 21'(zoom_step);
		else
			rad_sum = 21'(radius_q) - 21'(zoom_step);
		if (rad_sum[20] != rad_sum[19])
			rad_sat = rad_sum[20] ? 20'sh80000 : 20'sh7FFFF;
		else
			rad_sat = rad_sum[19:0];
	end

	assign el_in_range = !red_el_q[RW-1] && (red_el_q < TWO_PI_Q30);
	assign az_in_range = !red_az_q[RW-1] && (red_az_q < TWO_PI_Q30);
	assign stat.red_done = el_in_range && az_in_range;

	assign {fneg_el, fold_el} = fold_ang(red_el_q);
	assign {fneg_az, fold_az} = fold_ang(red_az_q);

	assign prod_rs = radius_q * st_q;
	assign prod_py = radius_q * ct_q;
	assign prod_px = rs_q * cp_q;
	assign prod_pz = rs_q * sp_q;

	// camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 20'(RST_INIT_RAD);
			az_q     <= '0;
			el_q     <= 18'(RST_INIT_EL);
			tx_q     <= '0;
			ty_q     <= '0;
			tz_q     <= '0;
			flip_q   <= 1'b0;
		end else if (ctl.apply) begin
			unique case (cmd_q.action)
				ACT_ORBIT: begin
					if (en_az_s1)
						az_q <= sat_ang(az_wrap);
					if (en_el_s1) begin
						el_q <= el_new;
						if ((el_lo < bot_s && bot_s < el_hi) ||
						    (el_lo < top_s && top_s < el_hi))
							flip_q <= !flip_q;
					end
				end
				ACT_ZOOM_OUT, ACT_ZOOM_IN: radius_q <= rad_sat;
				ACT_RETARGET: begin
					tx_q <= cmd_q.target_x;
					ty_q <= cmd_q.target_y;
					tz_q <= cmd_q.target_z;
				end
				ACT_LOAD: begin
					radius_q <= $signed({2'b00, cfg.initial_radius});
					az_q     <= 18'($signed(cfg.initial_azimuth));
					el_q     <= $signed({3'b000, cfg.initial_elevation});
					flip_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// item capture, orbit amounts, cordic and position pipeline
	always_ff @(posedge clk) begin
		if (ctl.ld_cmd)
			cmd_q <= cmd_data;
		if (ctl.amt) begin
			amt_az_s1 <= prod_x[32:12];
			amt_el_s1 <= prod_y[32:12];
			en_az_s1  <= mag_dx > 17'(cfg.dead_zone);
			en_el_s1  <= mag_dy > 17'(cfg.dead_zone);
			moved_q   <= (cmd_q.action == ACT_ORBIT) &&
			             ((mag_dx > 17'(cfg.dead_zone)) || (mag_dy > 17'(cfg.dead_zone)));
		end
		if (ctl.setup) begin
			red_el_q <= {el_q[17], el_q, 18'b0};
			red_az_q <= {az_q[17], az_q, 18'b0};
		end
		// one turn added or removed per cycle until in [0, 2pi)
		if (ctl.reduce) begin
			if (red_el_q[RW-1])
				red_el_q <= red_el_q + TWO_PI_Q30;
			else if (!el_in_range)
				red_el_q <= red_el_q - TWO_PI_Q30;
			if (red_az_q[RW-1])
				red_az_q <= red_az_q + TWO_PI_Q30;
			else if (!az_in_range)
				red_az_q <= red_az_q - TWO_PI_Q30;
		end
		if (ctl.fold) begin
			cor_el_q <= '{x: GAIN_Q30, y: '0, a: CW'(fold_el)};
			cor_az_q <= '{x: GAIN_Q30, y: '0, a: CW'(fold_az)};
			neg_el_q <= fneg_el;
			neg_az_q <= fneg_az;
		end
		if (ctl.rot) begin
			cor_el_q <= cordic_step(cor_el_q, ctl.iter);
			cor_az_q <= cordic_step(cor_az_q, ctl.iter);
		end
		if (ctl.sign) begin
			st_q <= neg_el_q ? -cor_el_q.y : cor_el_q.y;
			ct_q <= neg_el_q ? -cor_el_q.x : cor_el_q.x;
			sp_q <= neg_az_q ? -cor_az_q.y : cor_az_q.y;
			cp_q <= neg_az_q ? -cor_az_q.x : cor_az_q.x;
		end
		if (ctl.mul1) begin
			rs_q <= prod_rs[51:30];
			py_q <= prod_py[51:30];
		end
		if (ctl.mul2) begin
			px_q <= prod_px[51:30];
			pz_q <= prod_pz[51:30];
		end
		if (ctl.load_out) begin
			out_q.pos_x      <= sat_pos(25'(px_q) + 25'(tx_q));
			out_q.pos_y      <= sat_pos(25'(py_q) + 25'(ty_q));
			out_q.pos_z      <= sat_pos(25'(pz_q) + 25'(tz_q));
			out_q.up_flipped <= flip_q;
			out_q.moved      <= moved_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== design/orbit_camera_position_top.sv =====
// orbit_camera_position_top: orbit camera with register file, controller and datapath
// depends on ocp_pkg, ocp_chan_if, ocp_ctrl and ocp_dp
//
//  channel | dir | payload                                  | role
//  cmd     | in  | action, dir_x/y, target_x/y/z            | one camera action
//  pos     | out | pos_x/y/z, up_flipped, moved             | camera after action
//  cfg     | in  | index, wdata                             | register write
//
// an action runs from transfer to result register through angle reduction,
// which adds or removes one turn per cycle, and sixteen cordic iterations.
// arst_n resets the controller, the register file and the camera state.
// cmd is taken only while the controller idles; a result held by a stalled
// pos sink lets the next action run up to its final stage. cfg is always ready.
module orbit_camera_position_top (
	input  logic        clk,
	input  logic        arst_n,
	ocp_chan_if.sink    cmd,
	ocp_chan_if.source  pos,
	ocp_chan_if.sink    cfg
);
	import ocp_pkg::*;

	cfg_regs_t regs_q;
	ctl_cmd_t  ctl;
	dp_stat_t  stat;
	cfg_wr_t   cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.data;

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.move_speed        <= RST_MOVE_SPEED;
			regs_q.dead_zone         <= RST_DEAD_ZONE;
			regs_q.initial_radius    <= RST_INIT_RAD;
			regs_q.initial_azimuth   <= RST_INIT_AZ;
			regs_q.initial_elevation <= RST_INIT_EL;
			regs_q.bottom_angle      <= RST_BOTTOM;
			regs_q.top_angle         <= RST_TOP;
		end else if (cfg.valid) begin
			unique case (cfg_wr.index)
				REG_MOVE_SPEED: regs_q.move_speed        <= cfg_wr.wdata[15:0];
				REG_DEAD_ZONE:  regs_q.dead_zone         <= cfg_wr.wdata[11:0];
				REG_INIT_RAD:   regs_q.initial_radius    <= cfg_wr.wdata;
				REG_INIT_AZ:    regs_q.initial_azimuth   <= cfg_wr.wdata[15:0];
				REG_INIT_EL:    regs_q.initial_elevation <= cfg_wr.wdata[14:0];
				REG_BOTTOM:     regs_q.bottom_angle      <= cfg_wr.wdata[14:0];
				REG_TOP:        regs_q.top_angle         <= cfg_wr.wdata[14:0];
				default: ;
			endcase
		end
	end

	// sequencing
	ocp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.out_valid (pos.valid),
		.out_ready (pos.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	// arithmetic and camera state
	ocp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.cfg      (regs_q),
		.cmd_data (cmd.data),
		.out_data (pos.data)
	);

endmodule
